// ===== hdl/pdr_pkg.sv =====
package pdr_pkg;

	localparam int DUTY_WIDTH_DEF  = 8;
	localparam int RAMP_WIDTH      = 16;
	localparam int LEVEL_WIDTH     = 8;
	localparam int OUT_DUTY_WIDTH  = 8;
	localparam int CODE_WIDTH      = 8;
	localparam int CFG_INDEX_WIDTH = 4;
	localparam int CFG_DATA_WIDTH  = 16;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_RAMP_TIME = 4'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_HIGH      = 4'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MEDIUM    = 4'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOW       = 4'd3;

	localparam logic [RAMP_WIDTH-1:0]  RAMP_TIME_RST = 16'd5000;
	localparam logic [LEVEL_WIDTH-1:0] HIGH_RST      = 8'd254;
	localparam logic [LEVEL_WIDTH-1:0] MEDIUM_RST    = 8'd210;
	localparam logic [LEVEL_WIDTH-1:0] LOW_RST       = 8'd180;

	localparam logic [CODE_WIDTH-1:0] CMD_EMERGENCY_OFF = 8'd0;
	localparam logic [CODE_WIDTH-1:0] CMD_OFF           = 8'd10;
	localparam logic [CODE_WIDTH-1:0] CMD_HIGH          = 8'd255;
	localparam logic [CODE_WIDTH-1:0] CMD_MEDIUM        = 8'd127;
	localparam logic [CODE_WIDTH-1:0] CMD_LOW           = 8'd13;

	localparam logic REQ_COMMAND = 1'b0;
	localparam logic REQ_TICK    = 1'b1;

	typedef struct packed {
		logic                  req_type;
		logic [CODE_WIDTH-1:0] command_code;
	} in_item_t;

	typedef struct packed {
		logic [OUT_DUTY_WIDTH-1:0] duty;
		logic                      ramping;
	} out_item_t;

	typedef struct packed {
		logic accept;
		logic commit;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic needs_div;
		logic div_done;
	} dp_status_t;

endpackage

// ===== hdl/pwm_duty_ramp_controller.sv =====
// A tick, emergency off or ignored code goes from accept to the emit state and then into the
// output register once it is free; off/high/medium/low first wait in the divide state while the
// serial divider computes the interval. A new item waits until the previous one is emitted;
// but an item is taken while the previous result still waits in the output register.
// Reset: asynchronous, active low; duty, target, counter clear, interval is one, and the
// configuration registers return to their defaults.
module pwm_duty_ramp_controller
	import pdr_pkg::*;
#(
	parameter int DUTY_WIDTH = DUTY_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  in_item_t                   in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output out_item_t                  out_data,
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata
);

	dp_cmd_t    cmd;
	dp_status_t status;

	pdr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	pdr_datapath #(
		.DUTY_WIDTH(DUTY_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data)
	);

endmodule

// ===== hdl/pdr_divider.sv =====
module pdr_divider
	import pdr_pkg::*;
#(
	parameter int DIVISOR_WIDTH = DUTY_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [RAMP_WIDTH-1:0]    dividend,
	input  logic [DIVISOR_WIDTH-1:0] divisor,
	output logic [RAMP_WIDTH-1:0]    quotient,
	output logic                     done
);

	localparam int CNT_WIDTH = $clog2(RAMP_WIDTH);
	localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(RAMP_WIDTH - 1);

	logic [DIVISOR_WIDTH-1:0] rem_q;
	logic [DIVISOR_WIDTH-1:0] div_q;
	logic [RAMP_WIDTH-1:0]    quo_q;
	logic [CNT_WIDTH-1:0]     cnt_q;
	logic                     busy_q;
	logic                     done_q;

	logic [DIVISOR_WIDTH:0]   trial;
	logic [DIVISOR_WIDTH:0]   diff;
	logic                     ge;

	// restoring division, one quotient bit per cycle; dividend shifts out of quo_q
	assign trial = {rem_q, quo_q[RAMP_WIDTH-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
			quo_q <= {quo_q[RAMP_WIDTH-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ===== hdl/pdr_datapath.sv =====
module pdr_datapath
	import pdr_pkg::*;
#(
	parameter int DUTY_WIDTH = DUTY_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata,
	input  in_item_t                   in_data,
	input  dp_cmd_t                    cmd,
	output dp_status_t                 status,
	output out_item_t                  out_data
);

	logic [RAMP_WIDTH-1:0]  ramp_time_q;
	logic [LEVEL_WIDTH-1:0] high_q;
	logic [LEVEL_WIDTH-1:0] medium_q;
	logic [LEVEL_WIDTH-1:0] low_q;

	logic [DUTY_WIDTH-1:0]  cur_duty_q;
	logic [DUTY_WIDTH-1:0]  tgt_duty_q;
	logic [RAMP_WIDTH-1:0]  interval_q;
	logic [RAMP_WIDTH-1:0]  tick_q;
	out_item_t              out_q;

	logic [LEVEL_WIDTH-1:0] level;
	logic [DUTY_WIDTH-1:0]  level_duty;
	logic [DUTY_WIDTH-1:0]  steps;
	logic                   is_retarget;
	logic [RAMP_WIDTH-1:0]  tick_inc;
	logic [RAMP_WIDTH-1:0]  quotient;
	logic                   div_done;
	logic [RAMP_WIDTH-1:0]  interval_new;
	logic [15:0]            cur_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_time_q <= RAMP_TIME_RST;
			high_q      <= HIGH_RST;
			medium_q    <= MEDIUM_RST;
			low_q       <= LOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RAMP_TIME: ramp_time_q <= cfg_wdata[RAMP_WIDTH-1:0];
				REG_HIGH:      high_q      <= cfg_wdata[LEVEL_WIDTH-1:0];
				REG_MEDIUM:    medium_q    <= cfg_wdata[LEVEL_WIDTH-1:0];
				REG_LOW:       low_q       <= cfg_wdata[LEVEL_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		is_retarget = 1'b0;
		level       = '0;
		if (in_data.req_type == REQ_COMMAND) begin
			case (in_data.command_code)
				CMD_OFF: begin
					is_retarget = 1'b1;
				end
				CMD_HIGH: begin
					is_retarget = 1'b1;
					level       = high_q;
				end
				CMD_MEDIUM: begin
					is_retarget = 1'b1;
					level       = medium_q;
				end
				CMD_LOW: begin
					is_retarget = 1'b1;
					level       = low_q;
				end
				default: ;
			endcase
		end
	end

	assign level_duty = DUTY_WIDTH'(level);
	assign steps      = (level_duty >= cur_duty_q) ? (level_duty - cur_duty_q)
	                                               : (cur_duty_q - level_duty);
	assign tick_inc   = tick_q + 1'b1;

	pdr_divider #(
		.DIVISOR_WIDTH(DUTY_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.accept && is_retarget),
		.dividend (ramp_time_q),
		.divisor  (steps),
		.quotient (quotient),
		.done     (div_done)
	);

	// no steps, or ramp shorter than the step count: one tick minimum
	assign interval_new = (cur_duty_q == tgt_duty_q || quotient == '0)
	                      ? RAMP_WIDTH'(1) : quotient;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_duty_q <= '0;
			tgt_duty_q <= '0;
			interval_q <= RAMP_WIDTH'(1);
			tick_q     <= '0;
		end else if (cmd.accept) begin
			if (in_data.req_type == REQ_TICK) begin
				if (cur_duty_q == tgt_duty_q) begin
					tick_q <= '0;
				end else if (tick_inc >= interval_q) begin
					tick_q <= '0;
					if (cur_duty_q < tgt_duty_q) begin
						cur_duty_q <= cur_duty_q + 1'b1;
					end else begin
						cur_duty_q <= cur_duty_q - 1'b1;
					end
				end else begin
					tick_q <= tick_inc;
				end
			end else if (in_data.command_code == CMD_EMERGENCY_OFF) begin
				cur_duty_q <= '0;
				tgt_duty_q <= '0;
				interval_q <= RAMP_WIDTH'(1);
				tick_q     <= '0;
			end else if (is_retarget) begin
				tgt_duty_q <= level_duty;
				tick_q     <= '0;
			end
		end else if (cmd.commit) begin
			interval_q <= interval_new;
		end
	end

	assign cur_ext = 16'(cur_duty_q);

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.duty    <= cur_ext[OUT_DUTY_WIDTH-1:0];
			out_q.ramping <= cur_duty_q != tgt_duty_q;
		end
	end

	assign status.needs_div = is_retarget;
	assign status.div_done  = div_done;
	assign out_data         = out_q;

endmodule

// ===== hdl/pdr_ctrl.sv =====
module pdr_ctrl
	import pdr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d    = state_q;
		cmd.accept = 1'b0;
		cmd.commit = 1'b0;
		cmd.emit   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = status.needs_div ? S_DIV : S_EMIT;
				end
			end
			S_DIV: begin
				if (status.div_done) begin
					cmd.commit = 1'b1;
					state_d    = S_EMIT;
				end
			end
			S_EMIT: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;

endmodule

// ===== hdl/pdr_checker.sv =====
module pdr_checker
	import pdr_pkg::*;
(
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input in_item_t                   in_data,
	input logic                       out_valid,
	input logic                       out_stall,
	input out_item_t                  out_data,
	input logic                       cfg_we,
	input logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input logic [CFG_DATA_WIDTH-1:0]  cfg_wdata
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

	// one item at a time: the block is busy right after taking an item
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while the first is in work");

	// a fresh result appears only at the end of an item's work
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without an item in work");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> !$isunknown(in_data))
		else $error("accepted item has unknown fields");

	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !$isunknown({cfg_index, cfg_wdata}))
		else $error("register write with unknown index or data");

endmodule

bind pwm_duty_ramp_controller pdr_checker u_chk (.*);

// ===== test/pwm_duty_ramp_controller_test.sv =====
`timescale 1ns / 100ps

module pwm_duty_ramp_controller_test;
	import pdr_pkg::*;

	localparam int CYCLE_LIMIT   = 250000;
	localparam int SETTLE_CYCLES = 40;
	localparam int IDLE_PCT      = 36;
	localparam int MAX_GAP       = 8;
	localparam int REPORT_MAX    = 10;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 175;

	// custom speed code is not implemented and must be ignored
	localparam logic [CODE_WIDTH-1:0]      CMD_CUSTOM_SPEED = 8'd150;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_FIRST  = 4'd4;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_LAST   = 4'd15;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       in_valid  = 1'b0;
	logic                       in_stall;
	in_item_t                   in_data   = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	out_item_t                  out_data;
	logic                       cfg_we    = 1'b0;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [CFG_DATA_WIDTH-1:0]  cfg_wdata = '0;

	// ramp predictor state and configuration
	logic [RAMP_WIDTH-1:0]     ramp_ms        = RAMP_TIME_RST;
	logic [LEVEL_WIDTH-1:0]    level_high     = HIGH_RST;
	logic [LEVEL_WIDTH-1:0]    level_medium   = MEDIUM_RST;
	logic [LEVEL_WIDTH-1:0]    level_low      = LOW_RST;
	logic [OUT_DUTY_WIDTH-1:0] model_duty     = '0;
	logic [OUT_DUTY_WIDTH-1:0] model_target   = '0;
	logic [RAMP_WIDTH-1:0]     model_interval = 16'd1;
	logic [RAMP_WIDTH-1:0]     model_ticks    = '0;

	out_item_t expected_duty_q[$];

	bit src_idle_on  = 1'b1;
	bit sink_idle_on = 1'b1;
	int cycle_count    = 0;
	int item_total     = 0;
	int command_total  = 0;
	int step_total     = 0;
	int write_total    = 0;
	int result_total   = 0;
	int mismatch_total = 0;

	pwm_duty_ramp_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles, %0d results pending", cycle_count,
				expected_duty_q.size());
			$display("pwm_duty_ramp_controller_test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (sink_idle_on) begin
			out_stall <= ($urandom_range(99) < IDLE_PCT);
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic void note_mismatch(input string what, input int want, input int got);
		mismatch_total++;
		if (mismatch_total <= REPORT_MAX)
			$display("MISMATCH %s: expected %0d, got %0d (result %0d)", what, want, got,
				result_total);
	endfunction

	function automatic void retarget_duty(input logic [LEVEL_WIDTH-1:0] level);
		logic [OUT_DUTY_WIDTH-1:0] steps;
		logic [RAMP_WIDTH-1:0]     span;
		model_target = level;
		steps = (model_target >= model_duty) ? model_target - model_duty
			: model_duty - model_target;
		span = (steps != 0) ? ramp_ms / steps : 16'd1;
		if (span == 0)
			span = 16'd1;
		model_interval = span;
		model_ticks = '0;
	endfunction

	function automatic out_item_t advance_duty(input in_item_t it);
		out_item_t res;
		if (it.req_type == REQ_COMMAND) begin
			command_total++;
			case (it.command_code)
				CMD_EMERGENCY_OFF: begin
					model_duty = '0;
					model_target = '0;
					model_interval = 16'd1;
					model_ticks = '0;
				end
				CMD_OFF:    retarget_duty('0);
				CMD_HIGH:   retarget_duty(level_high);
				CMD_MEDIUM: retarget_duty(level_medium);
				CMD_LOW:    retarget_duty(level_low);
				default:    ;
			endcase
		end else if (model_duty == model_target) begin
			model_ticks = '0;
		end else begin
			model_ticks = model_ticks + 16'd1;
			if (model_ticks >= model_interval) begin
				model_ticks = '0;
				step_total++;
				if (model_duty < model_target) begin
					model_duty = model_duty + 1'b1;
				end else begin
					model_duty = model_duty - 1'b1;
				end
			end
		end
		res.duty = model_duty;
		res.ramping = (model_duty != model_target);
		return res;
	endfunction

	always @(posedge clk) begin : check_result
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_duty_q.size() == 0) begin
				note_mismatch("result with nothing pending, duty", -1, out_data.duty);
			end else begin
				want = expected_duty_q.pop_front();
				if (out_data.duty !== want.duty)
					note_mismatch("duty", want.duty, out_data.duty);
				if (out_data.ramping !== want.ramping)
					note_mismatch("ramping", want.ramping, out_data.ramping);
			end
			result_total++;
		end
	end

	function automatic in_item_t make_item(input logic req, input logic [CODE_WIDTH-1:0] code);
		in_item_t it;
		it.req_type = req;
		it.command_code = code;
		return it;
	endfunction

	function automatic logic [CODE_WIDTH-1:0] pick_ramp_command(input int sel);
		case (sel)
			0:       return CMD_EMERGENCY_OFF;
			1:       return CMD_OFF;
			2:       return CMD_HIGH;
			3:       return CMD_MEDIUM;
			default: return CMD_LOW;
		endcase
	endfunction

	// mostly ticks so ramps get to run; ticks carry random code bits
	function automatic in_item_t random_item();
		int roll;
		roll = $urandom_range(99);
		if (roll < 80)
			return make_item(REQ_TICK, CODE_WIDTH'($urandom_range(255)));
		if (roll < 94)
			return make_item(REQ_COMMAND, pick_ramp_command($urandom_range(4)));
		return make_item(REQ_COMMAND, CODE_WIDTH'($urandom_range(255)));
	endfunction

	// short ramp times keep the duty moving within a phase
	function automatic logic [RAMP_WIDTH-1:0] random_ramp_time();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			2, 3:    return RAMP_WIDTH'($urandom_range(3000, 300));
			default: return RAMP_WIDTH'($urandom_range(300, 1));
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
		input logic [CFG_DATA_WIDTH-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_RAMP_TIME: ramp_ms = data;
			REG_HIGH:      level_high = data[LEVEL_WIDTH-1:0];
			REG_MEDIUM:    level_medium = data[LEVEL_WIDTH-1:0];
			REG_LOW:       level_low = data[LEVEL_WIDTH-1:0];
			default:       ;
		endcase
		write_total++;
		@(posedge clk);
	endtask

	task automatic send_item(input in_item_t it);
		int gap;
		gap = 0;
		while (src_idle_on && gap < MAX_GAP && $urandom_range(99) < IDLE_PCT)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_duty_q.push_back(advance_duty(it));
		item_total++;
	endtask

	task automatic send_command(input logic [CODE_WIDTH-1:0] code);
		send_item(make_item(REQ_COMMAND, code));
	endtask

	task automatic send_ticks(input int count);
		repeat (count) send_item(make_item(REQ_TICK, CODE_WIDTH'($urandom_range(255))));
	endtask

	// hold the input back until every pending result is out
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_duty_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_commands_at_reset();
		send_ticks(1);
		send_command(CMD_CUSTOM_SPEED);
		send_command(CMD_HIGH);
		send_ticks(3);
		send_command(CMD_MEDIUM);
		send_command(CMD_LOW);
		send_command(CMD_EMERGENCY_OFF);
		// target already equals the duty
		send_command(CMD_OFF);
	endtask

	task automatic test_register_extremes();
		drain_results();
		write_reg(REG_RAMP_TIME, 16'd1);
		write_reg(REG_HIGH, 16'h00FF);
		write_reg(REG_MEDIUM, 16'hFF00);
		write_reg(REG_LOW, '0);
		write_reg(REG_SPARE_FIRST, '1);
		write_reg(REG_SPARE_LAST, '1);
		// interval rounds down to zero and is clamped to one tick
		send_command(CMD_HIGH);
		send_ticks(3);
		send_command(CMD_LOW);
		send_ticks(1);
		send_command(CMD_EMERGENCY_OFF);
		send_command(CMD_MEDIUM);
		drain_results();
		write_reg(REG_RAMP_TIME, '0);
		send_command(CMD_HIGH);
		send_ticks(2);
		drain_results();
		write_reg(REG_RAMP_TIME, 16'd510);
		send_command(CMD_HIGH);
		drain_results();
		// rewrite mid-ramp: running interval of two ticks must hold
		write_reg(REG_RAMP_TIME, '1);
		send_ticks(4);
		send_command(CMD_MEDIUM);
		send_ticks(1);
	endtask

	task automatic test_random_ramps();
		for (int phase = 0; phase < PHASES; phase++) begin
			drain_results();
			src_idle_on = (phase != 2);
			sink_idle_on = (phase != 2);
			write_reg(REG_RAMP_TIME, random_ramp_time());
			write_reg(REG_HIGH, CFG_DATA_WIDTH'($urandom_range(16'hFFFF)));
			write_reg(REG_MEDIUM, CFG_DATA_WIDTH'($urandom_range(16'hFFFF)));
			write_reg(REG_LOW, CFG_DATA_WIDTH'($urandom_range(16'hFFFF)));
			if (phase == 3)
				write_reg(CFG_INDEX_WIDTH'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
					CFG_DATA_WIDTH'($urandom_range(16'hFFFF)));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2) begin
					drain_results();
					write_reg(REG_RAMP_TIME, random_ramp_time());
				end
				send_item(random_item());
			end
		end
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_commands_at_reset();
		test_register_extremes();
		test_random_ramps();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_duty_q.size() != 0)
			note_mismatch("results never delivered", expected_duty_q.size(), 0);
		$display("Ran %0d items (%0d commands), %0d duty steps, %0d register writes.",
			item_total, command_total, step_total, write_total);
		$display("Compared %0d results, %0d mismatches.", result_total, mismatch_total);
		if (mismatch_total == 0) begin
			$display("pwm_duty_ramp_controller_test passed");
		end else begin
			$display("pwm_duty_ramp_controller_test failed");
		end
		$finish;
	end

endmodule
